[hw/rtl/trp_pkg.sv]
// package for the transport frame receive parser
// types, codes and constants shared by the front, queue, back and top level
// no dependencies
`default_nettype none

package trp_pkg;

  localparam logic [7:0] STATUS_TAG       = 8'h80;
  localparam logic [7:0] LEN_ESCAPE       = 8'd128;
  localparam logic [7:0] CREATE_REPLY_TAG = 8'h83;
  localparam logic [7:0] DELETE_REPLY_TAG = 8'h85;
  localparam logic [7:0] SB_DATA_VALUE    = 8'h80;
  localparam logic [7:0] SB_NODATA_VALUE  = 8'h00;
  localparam logic [7:0] SB_LENGTH        = 8'd2;
  localparam logic [7:0] EXP_ID_RESET     = 8'd1;

  localparam logic [1:0] SC_DATA    = 2'd0;
  localparam logic [1:0] SC_NODATA  = 2'd1;
  localparam logic [1:0] SC_INVALID = 2'd2;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LEN,
    PH_LEN2,
    PH_CONN,
    PH_BODY,
    PH_SBTAG,
    PH_SBLEN,
    PH_SBCONN,
    PH_SBVAL
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BODY      = 2'd0,
    KIND_SUMMARY   = 2'd1,
    KIND_MALFORMED = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } rx_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] body_byte;
    logic [7:0] frame_tag;
    logic [7:0] conn_id;
    logic [7:0] body_length;
    logic [1:0] status_class;
    logic       is_create_reply;
    logic       is_delete_reply;
    logic       last;
  } result_t;

  // classified byte handed from the front to the back
  typedef struct packed {
    kind_e      op;
    logic [7:0] data;
    logic [7:0] hdr_tag;
    logic [7:0] hdr_length;
    logic [7:0] hdr_conn;
    logic       sb_tag_ok;
    logic       sb_len_ok;
    logic [7:0] sb_conn;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/trp_front.sv]
// front of the receive parser: walks the frame phases byte by byte
// and issues a command for every byte that yields a result; uses trp_pkg
`default_nettype none

module trp_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  wire trp_pkg::rx_item_t in_item_i,
  output logic                   cmd_valid_o,
  output trp_pkg::cmd_t          cmd_o
);

  trp_pkg::phase_e phase_q, phase_d;
  logic [7:0] hdr_tag_q, hdr_tag_d;
  logic [7:0] hdr_length_q, hdr_length_d;
  logic [7:0] hdr_conn_q, hdr_conn_d;
  logic [7:0] body_left_q, body_left_d;
  logic       sb_tag_ok_q, sb_tag_ok_d;
  logic       sb_len_ok_q, sb_len_ok_d;
  logic [7:0] sb_conn_q, sb_conn_d;

  logic [7:0] b;
  logic [7:0] len_m1;

  assign b      = in_item_i.data_byte;
  assign len_m1 = hdr_length_q - 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= trp_pkg::PH_IDLE;
      hdr_tag_q    <= '0;
      hdr_length_q <= '0;
      hdr_conn_q   <= '0;
      body_left_q  <= '0;
      sb_tag_ok_q  <= 1'b0;
      sb_len_ok_q  <= 1'b0;
      sb_conn_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      hdr_tag_q    <= hdr_tag_d;
      hdr_length_q <= hdr_length_d;
      hdr_conn_q   <= hdr_conn_d;
      body_left_q  <= body_left_d;
      sb_tag_ok_q  <= sb_tag_ok_d;
      sb_len_ok_q  <= sb_len_ok_d;
      sb_conn_q    <= sb_conn_d;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    hdr_tag_d    = hdr_tag_q;
    hdr_length_d = hdr_length_q;
    hdr_conn_d   = hdr_conn_q;
    body_left_d  = body_left_q;
    sb_tag_ok_d  = sb_tag_ok_q;
    sb_len_ok_d  = sb_len_ok_q;
    sb_conn_d    = sb_conn_q;

    cmd_valid_o      = 1'b0;
    cmd_o.op         = trp_pkg::KIND_BODY;
    cmd_o.data       = b;
    cmd_o.hdr_tag    = hdr_tag_q;
    cmd_o.hdr_length = hdr_length_q;
    cmd_o.hdr_conn   = hdr_conn_q;
    cmd_o.sb_tag_ok  = sb_tag_ok_q;
    cmd_o.sb_len_ok  = sb_len_ok_q;
    cmd_o.sb_conn    = sb_conn_q;

    if (in_valid_i) begin
      if (in_item_i.frame_start) begin
        hdr_tag_d    = '0;
        hdr_length_d = '0;
        hdr_conn_d   = '0;
        body_left_d  = '0;
        sb_tag_ok_d  = 1'b0;
        sb_len_ok_d  = 1'b0;
        sb_conn_d    = '0;
        if (b == trp_pkg::STATUS_TAG) begin
          sb_tag_ok_d = 1'b1;
          phase_d     = trp_pkg::PH_SBLEN;
        end else begin
          hdr_tag_d = b;
          phase_d   = trp_pkg::PH_LEN;
        end
      end else begin
        case (phase_q)
          trp_pkg::PH_LEN, trp_pkg::PH_LEN2: begin
            if (phase_q == trp_pkg::PH_LEN && b >= trp_pkg::LEN_ESCAPE) begin
              phase_d = trp_pkg::PH_LEN2;
            end else if (b == 8'd0) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = trp_pkg::KIND_MALFORMED;
              phase_d     = trp_pkg::PH_IDLE;
            end else begin
              hdr_length_d = b;
              phase_d      = trp_pkg::PH_CONN;
            end
          end
          trp_pkg::PH_CONN: begin
            hdr_conn_d  = b;
            body_left_d = len_m1;
            phase_d     = (len_m1 != 8'd0) ? trp_pkg::PH_BODY : trp_pkg::PH_SBTAG;
          end
          trp_pkg::PH_BODY: begin
            cmd_valid_o = 1'b1;
            cmd_o.op    = trp_pkg::KIND_BODY;
            body_left_d = body_left_q - 8'd1;
            if (body_left_q == 8'd1) begin
              phase_d = trp_pkg::PH_SBTAG;
            end
          end
          trp_pkg::PH_SBTAG: begin
            sb_tag_ok_d = (b == trp_pkg::STATUS_TAG);
            phase_d     = trp_pkg::PH_SBLEN;
          end
          trp_pkg::PH_SBLEN: begin
            sb_len_ok_d = (b == trp_pkg::SB_LENGTH);
            phase_d     = trp_pkg::PH_SBCONN;
          end
          trp_pkg::PH_SBCONN: begin
            sb_conn_d = b;
            phase_d   = trp_pkg::PH_SBVAL;
          end
          trp_pkg::PH_SBVAL: begin
            cmd_valid_o = 1'b1;
            cmd_o.op    = trp_pkg::KIND_SUMMARY;
            phase_d     = trp_pkg::PH_IDLE;
          end
          default: begin
            phase_d = trp_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/trp_queue.sv]
// short command queue between the parser front and the result back
// register file with read and write pointers; uses trp_pkg
`default_nettype none

module trp_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                wr_en_i,
  input  wire trp_pkg::cmd_t wr_data_i,
  input  wire                rd_en_i,
  output trp_pkg::cmd_t      rd_data_o,
  output logic               avail_o,
  output logic               full_o
);

  trp_pkg::cmd_t mem_q [trp_pkg::QDEPTH];

  logic [trp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [trp_pkg::QCNT_W-1:0] count_q;

  assign avail_o   = (count_q != '0);
  assign full_o    = (count_q == trp_pkg::QCNT_W'(trp_pkg::QDEPTH));
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({wr_en_i, rd_en_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/trp_back.sv]
// back of the receive parser: turns queued commands into result transactions
// and holds the result register read by the consumer; uses trp_pkg
`default_nettype none

module trp_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire [7:0]          exp_id_i,
  input  wire                cmd_avail_i,
  input  wire trp_pkg::cmd_t cmd_i,
  output logic               cmd_take_o,
  input  wire                pop_i,
  output logic               valid_o,
  output trp_pkg::result_t   result_o
);

  logic             valid_q;
  trp_pkg::result_t res_q, res_d;
  logic             sb_ok;
  logic             rep_ok;

  assign cmd_take_o = cmd_avail_i && (!valid_q || pop_i);
  assign valid_o    = valid_q;
  assign result_o   = res_q;

  assign sb_ok  = cmd_i.sb_tag_ok && cmd_i.sb_len_ok && (cmd_i.sb_conn == exp_id_i);
  assign rep_ok = (cmd_i.hdr_length == 8'd1) && (cmd_i.hdr_conn == exp_id_i);

  always_comb begin
    res_d                 = '0;
    res_d.kind            = cmd_i.op;
    case (cmd_i.op)
      trp_pkg::KIND_BODY: begin
        res_d.body_byte = cmd_i.data;
      end
      trp_pkg::KIND_SUMMARY: begin
        res_d.frame_tag   = cmd_i.hdr_tag;
        res_d.conn_id     = (cmd_i.hdr_conn != 8'd0) ? cmd_i.hdr_conn : cmd_i.sb_conn;
        res_d.body_length = (cmd_i.hdr_length != 8'd0) ? (cmd_i.hdr_length - 8'd1) : 8'd0;
        res_d.status_class = trp_pkg::SC_INVALID;
        if (sb_ok && cmd_i.data == trp_pkg::SB_DATA_VALUE) begin
          res_d.status_class = trp_pkg::SC_DATA;
        end else if (sb_ok && cmd_i.data == trp_pkg::SB_NODATA_VALUE) begin
          res_d.status_class = trp_pkg::SC_NODATA;
        end
        res_d.is_create_reply = rep_ok && (cmd_i.hdr_tag == trp_pkg::CREATE_REPLY_TAG);
        res_d.is_delete_reply = rep_ok && (cmd_i.hdr_tag == trp_pkg::DELETE_REPLY_TAG);
        res_d.last            = 1'b1;
      end
      trp_pkg::KIND_MALFORMED: begin
        res_d.frame_tag = cmd_i.hdr_tag;
        res_d.last      = 1'b1;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tpdu_receive_parser.sv]
// Receive parser for transport frames: input byte queue port, result queue port.
// Input: drive rx_item_i and raise push; a byte is taken on a rising edge with
//   push high and full low. frame_start marks the first byte of a frame and
//   restarts parsing at any time; stray bytes while idle are dropped.
// Output: while empty is low, result_o holds the oldest result (body byte,
//   frame summary or malformed frame); raise pop to take it.
// Configuration: cfg_we_i writes cfg_wdata_i into the expected connection id
//   on the same edge; write it only while no frame is being processed.
// Throughput: one byte per cycle while full is low. The front parser
//   classifies each byte in the cycle it is taken and writes a command for
//   each byte that yields a result into a four-entry queue; the back formats
//   one command per cycle into the result register while it is empty or popped.
//   A byte's command enters the queue on the edge that takes the byte.
// Stall: with pop low the result register and the command queue fill; full
//   rises once the queue holds four commands and no byte is taken until the
//   consumer pops again.
// Reset: asynchronous and active low; parser idle, queue and result empty,
//   expected connection id back to 1.
// Depends on trp_pkg, trp_front, trp_queue and trp_back.
`default_nettype none

module tpdu_receive_parser (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push,
  output logic                   full,
  input  wire trp_pkg::rx_item_t rx_item_i,
  output logic                   empty,
  input  wire                    pop,
  output trp_pkg::result_t       result_o,
  input  wire                    cfg_we_i,
  input  wire [7:0]              cfg_wdata_i
);

  logic [7:0]    exp_id_q;
  logic          in_accept;
  logic          cmd_push;
  trp_pkg::cmd_t cmd_wr;
  trp_pkg::cmd_t cmd_rd;
  logic          cmd_avail;
  logic          cmd_take;
  logic          q_full;
  logic          res_valid;

  assign in_accept = push && !q_full;
  assign full      = q_full;
  assign empty     = !res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q <= trp_pkg::EXP_ID_RESET;
    end else if (cfg_we_i) begin
      exp_id_q <= cfg_wdata_i;
    end
  end

  trp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_accept),
    .in_item_i   (rx_item_i),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_wr)
  );

  trp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (cmd_wr),
    .rd_en_i   (cmd_take),
    .rd_data_o (cmd_rd),
    .avail_o   (cmd_avail),
    .full_o    (q_full)
  );

  trp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .exp_id_i    (exp_id_q),
    .cmd_avail_i (cmd_avail),
    .cmd_i       (cmd_rd),
    .cmd_take_o  (cmd_take),
    .pop_i       (pop),
    .valid_o     (res_valid),
    .result_o    (result_o)
  );

  // queue never written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_push && q_full))
    else $error("command queue overflow");

  // frame-ending results and only those carry last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.last == (result_o.kind != trp_pkg::KIND_BODY)))
    else $error("last flag does not match result kind");

  // a command taken by the back shows up as a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_take |=> !empty)
    else $error("taken command did not reach the result register");

endmodule

`default_nettype wire
